[hw/rtl/ims_pkg.sv]
// ims_pkg: shared constants, register indexes and the controller/datapath
// command and status types of the Ising Metropolis site updater.
// No dependencies.
package ims_pkg;

   localparam int SIDE_DEF      = 32;
   localparam int RAND_BITS_DEF = 12;

   localparam int ROW_W       = 5;
   localparam int RAND_W      = 12;
   localparam int MAG_W       = 12;
   localparam int FIELD_W     = 16;
   localparam int THR_W       = 60;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;
   localparam int LOC_W       = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_H  = 2'd0,
      CSR_THR_UP   = 2'd1,
      CSR_THR_DOWN = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_NBR,
      ST_RD_CTR,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_item;
      logic rd_nbr;
      logic rd_ctr;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/ising_metropolis_site_update.sv]
// Ising Metropolis site updater on a SIDE x SIDE wrapped spin lattice held
// as one row per memory word (two read ports, one write port). An item passes
// from acceptance to result through the accept cycle, a read of the two
// neighbouring rows, a read of the site's own row, then evaluation with
// write-back; the next item is accepted once the result is registered, so no
// new item is taken before the last is through, as the lattice reads are
// sequential. A result waiting at the output holds the block only at
// evaluation. After reset a clearing pass sets the lattice to all up, during
// which no item is taken; configuration writes are taken at any time.
// Depends on ims_pkg, ims_ctrl and ims_datapath.
module ising_metropolis_site_update
   import ims_pkg::*;
#(
   parameter int SIDE      = SIDE_DEF,
   parameter int RAND_BITS = RAND_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // row[4:0], col[9:5], rand_u[21:10], spin_value[22], zero[23]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // mode[0]
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // flipped[0], spin_now[1], magnetization[13:2], zero[15:14]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [THR_W-1:0]       csr_data
);

   cmd_type          cmd;
   status_type       status;
   logic             out_flipped, out_spin_now;
   logic [MAG_W-1:0] out_magnetization;

   ims_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ims_datapath #(
      .SIDE      (SIDE),
      .RAND_BITS (RAND_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_mode           (req_tuser[0]),
      .in_row            (req_tdata[4:0]),
      .in_col            (req_tdata[9:5]),
      .in_rand_u         (req_tdata[21:10]),
      .in_spin_value     (req_tdata[22]),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .out_flipped       (out_flipped),
      .out_spin_now      (out_spin_now),
      .out_magnetization (out_magnetization)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {2'b00, out_magnetization, out_spin_now, out_flipped};

endmodule

[hw/rtl/ims_ctrl.sv]
// ims_ctrl: sequencing state machine of the site updater.
// Depends on ims_pkg.
module ims_ctrl
   import ims_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_RD_NBR;
         end
         ST_RD_NBR: state_in = ST_RD_CTR;
         ST_RD_CTR: state_in = ST_EVAL;
         ST_EVAL: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.clear_wr  = (state_ff == ST_CLEAR);
      cmd.load_item = (state_ff == ST_IDLE) && req_valid;
      cmd.rd_nbr    = (state_ff == ST_RD_NBR);
      cmd.rd_ctr    = (state_ff == ST_RD_CTR);
      cmd.finish    = (state_ff == ST_EVAL) && status.out_free;
   end

endmodule

[hw/rtl/ims_datapath.sv]
// ims_datapath: lattice row memory, configuration registers, energy test,
// spin total and result register of the site updater.
// Depends on ims_pkg.
module ims_datapath
   import ims_pkg::*;
#(
   parameter int SIDE      = SIDE_DEF,
   parameter int RAND_BITS = RAND_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  in_mode,
   input  logic [ROW_W-1:0]      in_row,
   input  logic [ROW_W-1:0]      in_col,
   input  logic [RAND_W-1:0]     in_rand_u,
   input  logic                  in_spin_value,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [THR_W-1:0]      csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  out_flipped,
   output logic                  out_spin_now,
   output logic [MAG_W-1:0]      out_magnetization
);

   localparam int IDX_W = $clog2(SIDE);
   localparam int SITES = SIDE * SIDE;
   localparam int CMP_W = (RAND_BITS > RAND_W) ? RAND_BITS : RAND_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIDE - 1);
   localparam logic [MAG_W-1:0] TOTAL_RST = MAG_W'(SITES);
   localparam logic [CMP_W-1:0] RMASK = CMP_W'((64'd1 << RAND_BITS) - 64'd1);

   // one lattice row per word, bit = 1 for an up spin
   logic [SIDE-1:0] lattice_mem [SIDE];

   logic [IDX_W-1:0]   clr_ff;
   logic [FIELD_W-1:0] field_h_ff;
   logic [THR_W-1:0]   thr_up_ff, thr_dn_ff;
   logic [MAG_W-1:0]   total_ff, total_in;

   logic               mode_ff, wval_ff, in_range_ff;
   logic [IDX_W-1:0]   row_ff, col_ff, up_ff, dn_ff;
   logic [CMP_W-1:0]   u_ff;
   logic [SIDE-1:0]    rd_a_ff, rd_b_ff;
   logic               nbr_up_ff, nbr_dn_ff;

   logic               rsp_valid_ff, flipped_ff, spin_now_ff;
   logic [MAG_W-1:0]   mag_ff;

   logic               in_range_in;
   logic [IDX_W-1:0]   row_in, up_in, dn_in, addr_a, lcol, rcol;
   logic               cur, nbr_l, nbr_r, favourable, accept, next_spin, flip;
   logic [2:0]         n_up, k_sel;
   logic [LOC_W-1:0]   loc_field;
   logic [THR_W-1:0]   thr_reg;
   logic [7:0]         shamt;
   logic [63:0]        thr_shift;
   logic [CMP_W-1:0]   thr_val;
   logic [SIDE-1:0]    row_new;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         field_h_ff <= '0;
         thr_up_ff  <= '0;
         thr_dn_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIELD_H:  field_h_ff <= csr_data[FIELD_W-1:0];
            CSR_THR_UP:   thr_up_ff  <= csr_data;
            CSR_THR_DOWN: thr_dn_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // item capture and wrap addresses
   always_comb begin
      in_range_in = ({{(32-ROW_W){1'b0}}, in_row} < 32'(SIDE))
                 && ({{(32-ROW_W){1'b0}}, in_col} < 32'(SIDE));
      row_in = IDX_W'(in_row);
      up_in  = (row_in == '0) ? LAST_IDX : row_in - 1'b1;
      dn_in  = (row_in == LAST_IDX) ? '0 : row_in + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff     <= in_mode;
         wval_ff     <= in_spin_value;
         in_range_ff <= in_range_in;
         row_ff      <= row_in;
         col_ff      <= IDX_W'(in_col);
         up_ff       <= up_in;
         dn_ff       <= dn_in;
         u_ff        <= CMP_W'(in_rand_u) & RMASK;
      end
   end

   // clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign addr_a = cmd.clear_wr ? clr_ff : (cmd.rd_nbr ? up_ff : row_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         lattice_mem[clr_ff] <= '1;
      end else if (cmd.finish && flip) begin
         lattice_mem[row_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= lattice_mem[addr_a];
      rd_b_ff <= lattice_mem[dn_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_ctr) begin
         nbr_up_ff <= rd_a_ff[col_ff];
         nbr_dn_ff <= rd_b_ff[col_ff];
      end
   end

   // evaluation on the centre row
   always_comb begin
      lcol  = (col_ff == '0) ? LAST_IDX : col_ff - 1'b1;
      rcol  = (col_ff == LAST_IDX) ? '0 : col_ff + 1'b1;
      cur   = rd_a_ff[col_ff];
      nbr_l = rd_a_ff[lcol];
      nbr_r = rd_a_ff[rcol];
      n_up  = 3'(nbr_up_ff) + 3'(nbr_dn_ff) + 3'(nbr_l) + 3'(nbr_r);
      // 1024 * (2n - 4) + H
      loc_field = LOC_W'({n_up, 11'b0}) - LOC_W'(4096)
                + {{(LOC_W-FIELD_W){field_h_ff[FIELD_W-1]}}, field_h_ff};
      if (cur) begin
         favourable = loc_field[LOC_W-1] || (loc_field == '0);
      end else begin
         favourable = !loc_field[LOC_W-1];
      end
      k_sel     = cur ? n_up : 3'(3'd4 - n_up);
      thr_reg   = cur ? thr_up_ff : thr_dn_ff;
      shamt     = 8'(32'(k_sel) * RAND_BITS);
      thr_shift = {{(64-THR_W){1'b0}}, thr_reg} >> shamt;
      if (shamt >= 8'd64) begin
         thr_val = '0;
      end else begin
         thr_val = CMP_W'(thr_shift[RAND_BITS-1:0]);
      end
      accept    = favourable || (u_ff < thr_val);
      next_spin = mode_ff ? wval_ff : (cur ^ accept);
      flip      = in_range_ff && (next_spin != cur);
      row_new   = rd_a_ff;
      row_new[col_ff] = next_spin;
      total_in  = total_ff + (next_spin ? MAG_W'(2) : MAG_W'(-2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RST;
      end else if (cmd.finish && flip) begin
         total_ff <= total_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         flipped_ff  <= flip;
         spin_now_ff <= in_range_ff && next_spin;
         mag_ff      <= flip ? total_in : total_ff;
      end
   end

   assign status.clear_last = (clr_ff == LAST_IDX);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign out_flipped       = flipped_ff;
   assign out_spin_now      = spin_now_ff;
   assign out_magnetization = mag_ff;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for ising_metropolis_site_update: mirrors the spin lattice,
// the spin total and the registers, and checks every result item in order.
// Depends on ims_pkg and the RTL of the block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ims_pkg::*;

   localparam int SIDE = SIDE_DEF;
   localparam int SITES = SIDE * SIDE;
   localparam bit MODE_ATTEMPT = 1'b0;
   localparam bit MODE_WRITE = 1'b1;
   localparam bit SPIN_DOWN = 1'b0;
   localparam bit SPIN_UP = 1'b1;

   typedef struct {
      bit                mode;
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  col;
      logic [RAND_W-1:0] rand_u;
      bit                spin_value;
   } site_item_type;

   typedef struct {
      bit               flipped;
      bit               spin_now;
      logic [MAG_W-1:0] magnetization;
   } site_result_type;

   class site_update_tracker_type;
      bit                        lattice[SITES];
      int                        spin_total;
      logic signed [FIELD_W-1:0] field_h;
      logic [THR_W-1:0]          thr_up;
      logic [THR_W-1:0]          thr_down;
      site_result_type           pending_results[$];
      int                        mismatches;

      function new();
         for (int i = 0; i < SITES; i++) lattice[i] = SPIN_UP;
         spin_total = SITES;
         field_h = '0;
         thr_up = '0;
         thr_down = '0;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [THR_W-1:0] value);
         case (idx)
            CSR_FIELD_H: field_h = value[FIELD_W-1:0];
            CSR_THR_UP: thr_up = value;
            CSR_THR_DOWN: thr_down = value;
            default: ;
         endcase
      endfunction

      function int spin_sign(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c);
         return lattice[r * SIDE + c] ? 1 : -1;
      endfunction

      // accepted input: predict flip, spin and total
      function void note_item(site_item_type it);
         int idx, nsum, h, loc, k;
         bit cur, nxt, acc;
         logic [ROW_W-1:0] r_up, r_dn, c_lf, c_rt;
         logic [RAND_W-1:0] thr;
         site_result_type res;
         idx = it.row * SIDE + it.col;
         cur = lattice[idx];
         nxt = cur;
         if (it.mode == MODE_WRITE) begin
            nxt = it.spin_value;
         end else begin
            r_up = it.row - 1'b1;
            r_dn = it.row + 1'b1;
            c_lf = it.col - 1'b1;
            c_rt = it.col + 1'b1;
            nsum = spin_sign(r_up, it.col) + spin_sign(r_dn, it.col)
                 + spin_sign(it.row, c_lf) + spin_sign(it.row, c_rt);
            h = int'(field_h);
            loc = nsum * 1024 + h;
            if ((cur ? loc : -loc) <= 0) begin
               acc = 1'b1;
            end else begin
               k = cur ? (nsum + 4) / 2 : (4 - nsum) / 2;
               thr = cur ? thr_up[k*RAND_W +: RAND_W] : thr_down[k*RAND_W +: RAND_W];
               acc = it.rand_u < thr;
            end
            if (acc) nxt = ~cur;
         end
         res.flipped = (nxt != cur);
         if (nxt != cur) begin
            lattice[idx] = nxt;
            spin_total += nxt ? 2 : -2;
         end
         res.spin_now = nxt;
         res.magnetization = spin_total[MAG_W-1:0];
         pending_results.push_back(res);
      endfunction

      function void note_mismatch(string what, int unsigned exp_v, int unsigned act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data);
         site_result_type exp_r;
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected item", 0, data);
            return;
         end
         exp_r = pending_results.pop_front();
         if (exp_r.flipped !== data[0]) note_mismatch("flipped", exp_r.flipped, data[0]);
         if (exp_r.spin_now !== data[1]) note_mismatch("spin_now", exp_r.spin_now, data[1]);
         if (exp_r.magnetization !== data[13:2])
            note_mismatch("magnetization", exp_r.magnetization, data[13:2]);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [0:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   csr_index_type          csr_index;
   logic [THR_W-1:0]       csr_data;

   int idle_pct;
   int stall_pct;
   site_update_tracker_type tracker = new();

   ising_metropolis_site_update i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("[ising_metropolis_site_update] ERROR");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata);
   end

   function automatic site_item_type make_item(bit mode, int row, int col, int rnd, bit wval);
      site_item_type it;
      it.mode = mode;
      it.row = ROW_W'(row);
      it.col = ROW_W'(col);
      it.rand_u = RAND_W'(rnd);
      it.spin_value = wval;
      return it;
   endfunction

   // mostly a small wrapped window so neighbour patterns vary
   function automatic site_item_type random_site_item();
      site_item_type it;
      int sel;
      it.mode = ($urandom_range(99) < 25) ? MODE_WRITE : MODE_ATTEMPT;
      if ($urandom_range(99) < 60) begin
         it.row = ROW_W'($urandom_range(3) + 31);
         it.col = ROW_W'($urandom_range(3) + 31);
      end else begin
         it.row = ROW_W'($urandom_range(SIDE - 1));
         it.col = ROW_W'($urandom_range(SIDE - 1));
      end
      sel = $urandom_range(9);
      it.rand_u = (sel == 0) ? '0 : (sel == 1) ? '1 : RAND_W'($urandom_range(4095));
      it.spin_value = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic logic [THR_W-1:0] random_thresholds();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[THR_W-1:0];
   endfunction

   task automatic send_site_item(input site_item_type it);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tdata <= {1'b0, it.spin_value, it.rand_u, it.col, it.row};
      do @(posedge clock); while (!req_tready);
      tracker.note_item(it);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [FIELD_W-1:0] field, input logic [THR_W-1:0] up,
                            input logic [THR_W-1:0] down);
      write_reg(CSR_FIELD_H, THR_W'(field));
      write_reg(CSR_THR_UP, up);
      write_reg(CSR_THR_DOWN, down);
      csr_valid <= 1'b0;
   endtask

   initial begin
      site_item_type it;
      logic [FIELD_W-1:0] field;
      logic [THR_W-1:0] up, down;
      int count;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FIELD_H;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // thresholds laid out {k4, k3, k2, k1, k0}
      configure(16'sd0, {12'h800, 12'h123, 12'hFFF, 12'h000, 12'h456},
                {12'hFFF, 12'h000, 12'h800, 12'h7FF, 12'h001});
      send_site_item(make_item(MODE_ATTEMPT, 0, 0, 'h7FF, SPIN_UP));
      send_site_item(make_item(MODE_ATTEMPT, 0, 0, 'hFFF, SPIN_DOWN));
      send_site_item(make_item(MODE_ATTEMPT, 31, 31, 'h800, SPIN_UP));
      send_site_item(make_item(MODE_ATTEMPT, 31, 31, 'h000, SPIN_UP));
      send_site_item(make_item(MODE_WRITE, 31, 31, 'hFFF, SPIN_DOWN));
      send_site_item(make_item(MODE_WRITE, 31, 31, 'h000, SPIN_UP));
      send_site_item(make_item(MODE_WRITE, 31, 0, 'h555, SPIN_DOWN));
      send_site_item(make_item(MODE_WRITE, 0, 31, 'hAAA, SPIN_DOWN));
      // zero energy change: flips either way
      send_site_item(make_item(MODE_ATTEMPT, 0, 0, 'hFFF, SPIN_UP));
      send_site_item(make_item(MODE_ATTEMPT, 0, 0, 'hFFF, SPIN_DOWN));
      send_site_item(make_item(MODE_WRITE, 1, 0, 'h000, SPIN_DOWN));
      send_site_item(make_item(MODE_ATTEMPT, 0, 0, 'hFFF, SPIN_UP));
      send_site_item(make_item(MODE_ATTEMPT, 0, 0, 'h000, SPIN_UP));
      send_site_item(make_item(MODE_WRITE, 0, 0, 'h000, SPIN_UP));
      send_site_item(make_item(MODE_WRITE, 31, 0, 'h000, SPIN_UP));
      send_site_item(make_item(MODE_WRITE, 0, 31, 'h000, SPIN_UP));
      send_site_item(make_item(MODE_WRITE, 1, 0, 'h000, SPIN_UP));
      send_site_item(make_item(MODE_WRITE, 21, 10, 'hFFF, SPIN_DOWN));
      send_site_item(make_item(MODE_ATTEMPT, 10, 21, 'h001, SPIN_DOWN));
      send_site_item(make_item(MODE_ATTEMPT, 22, 10, 'hFFE, SPIN_UP));
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 75; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 75; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         up = random_thresholds();
         down = random_thresholds();
         field = FIELD_W'($urandom);
         case (phase)
            0: field = '0;
            1: begin field = 16'h7FFF; up = {5{12'hFFF}}; end
            2: field = -16'sd2048;
            3: begin field = 16'h8000; down = '0; end
            4: begin up = '0; down = '0; end
            5: field = 16'h7FFF;
            6: field = FIELD_W'($urandom_range(8192) - 4096);
            default: begin up = {5{12'hFFF}}; down = {5{12'hFFF}}; end
         endcase
         configure(field, up, down);
         // strongest negative field drives every site down in a raster sweep
         count = (phase == 3) ? SITES : 110;
         for (int n = 0; n < count; n++) begin
            if (phase == 3)
               it = make_item(MODE_ATTEMPT, n / SIDE, n % SIDE, $urandom_range(4095),
                              1'($urandom_range(1)));
            else
               it = random_site_item();
            send_site_item(it);
            if (phase == 0 && n == count / 2) wait_drained();
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
         $display("[ising_metropolis_site_update] OK");
      else
         $display("[ising_metropolis_site_update] ERROR");
      $finish;
   end

endmodule
